// File: rtl/fgvo_pkg.sv
// shared constants, coefficient tables and table builders for the velocity observer
package fgvo_pkg;

    // field widths and counts
    localparam int IN_W    = 16;
    localparam int EST_W   = 16;
    localparam int N_MEAS  = 5;
    localparam int N_EST   = 3;
    localparam int Y_W     = 24;
    localparam int SAT_W   = Y_W + 1;
    localparam int CNT_W   = $clog2(Y_W);
    localparam int Z_SHIFT = 4;

    // coefficient precision
    localparam int HELD_FRAC          = 30;
    localparam int COEF_FRAC_BITS_DEF = 24;

    // saturation bounds of the estimate
    localparam logic signed [SAT_W-1:0] EST_MAX_S = SAT_W'(32767);
    localparam logic signed [SAT_W-1:0] EST_MIN_S = -SAT_W'(32768);

    // measurement matrix, 30 fractional bits, 5 rows by 3 columns
    localparam longint H_Q30 [N_MEAS][N_EST] = '{
        '{ 64'sd19270312706,  64'sd33377160685, -64'sd3077761848 },
        '{-64'sd24254401456,  64'sd29951691392, -64'sd3077761848 },
        '{-64'sd24254401456, -64'sd29951691392, -64'sd3077761848 },
        '{ 64'sd19270312706, -64'sd33377160685, -64'sd3077761848 },
        '{ 64'sd0,            64'sd0,            64'sd1073741824 }
    };

    // gain matrix, 30 fractional bits, 3 rows by 5 columns
    localparam longint K_Q30 [N_EST][N_MEAS] = '{
        '{ 64'sd1009050, -64'sd1269992, -64'sd1269992,  64'sd1009050, -64'sd1210785   },
        '{ 64'sd391318,   64'sd351157,  -64'sd351157,  -64'sd391318,   64'sd0         },
        '{-64'sd4266,    -64'sd4020,    -64'sd4020,    -64'sd4266,     64'sd290050615 }
    };

    // round a held coefficient to frac fractional bits, half up
    function automatic longint coef_round(input longint c30, input int frac);
        longint v;
        int     s;
        s = HELD_FRAC - frac;
        if (s == 0) begin
            return c30;
        end
        v = c30 + (longint'(1) <<< (s - 1));
        return v >>> s;
    endfunction

    // sum of the measurement row coefficients selected by mask
    function automatic longint meas_sum(input int row, input int mask, input int frac);
        longint acc;
        acc = 0;
        for (int j = 0; j < N_EST; j++) begin
            if (mask[j]) begin
                acc = acc + coef_round(H_Q30[row][j], frac);
            end
        end
        return acc;
    endfunction

    // sum of the gain row coefficients selected by mask
    function automatic longint gain_sum(input int row, input int mask, input int frac);
        longint acc;
        acc = 0;
        for (int i = 0; i < N_MEAS; i++) begin
            if (mask[i]) begin
                acc = acc + coef_round(K_Q30[row][i], frac);
            end
        end
        return acc;
    endfunction

endpackage

// File: rtl/fixed_gain_velocity_observer_top.sv
// fixed-gain velocity observer: bit-serial distributed-arithmetic measurement update
//
// Each transfer of four wheel speeds and a gyro rate (Q7.8) updates the stored
// body-velocity estimate (vx, vy, omega, Q3.12, saturated, zero after reset) and
// returns it as one result. A new input is taken only in the idle state, once the
// previous estimate has been written. The estimate is shifted MSB first through
// the predicted-measurement tables, the 24-bit residuals are formed, the
// residuals are shifted MSB first through the gain tables, and a final step
// writes the estimate and the output. The write waits while an earlier result
// has not been taken; the output ports show the stored estimate, so they hold
// steady until the output transfer.
module fixed_gain_velocity_observer_top
    import fgvo_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [IN_W-1:0]  i_wheel_speed_a,
    input  logic signed [IN_W-1:0]  i_wheel_speed_b,
    input  logic signed [IN_W-1:0]  i_wheel_speed_c,
    input  logic signed [IN_W-1:0]  i_wheel_speed_d,
    input  logic signed [IN_W-1:0]  i_gyro_rate,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [EST_W-1:0] o_est_vx,
    output logic signed [EST_W-1:0] o_est_vy,
    output logic signed [EST_W-1:0] o_est_omega
);

    localparam int ACC_W = COEF_FRAC_BITS + 24;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MEAS   = 5'b00010,
        S_RESID  = 5'b00100,
        S_GAIN   = 5'b01000,
        S_UPDATE = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    logic signed [EST_W-1:0] r_est [N_EST];
    logic signed [EST_W-1:0] n_est [N_EST];
    logic signed [ACC_W-1:0] r_acc [N_MEAS];
    logic signed [ACC_W-1:0] n_acc [N_MEAS];
    logic [EST_W-1:0]        r_xs  [N_EST];
    logic [EST_W-1:0]        n_xs  [N_EST];
    logic [Y_W-1:0]          r_ys  [N_MEAS];
    logic [Y_W-1:0]          n_ys  [N_MEAS];
    logic signed [IN_W-1:0]  r_z   [N_MEAS];
    logic signed [IN_W-1:0]  n_z   [N_MEAS];

    logic signed [ACC_W-1:0] w_meas_tab [N_MEAS][1 << N_EST];
    logic signed [ACC_W-1:0] w_gain_tab [N_EST][1 << N_MEAS];
    logic [N_EST-1:0]        w_xbits;
    logic [N_MEAS-1:0]       w_ybits;
    logic signed [ACC_W-1:0] w_t   [N_MEAS];
    logic signed [ACC_W-1:0] w_tsh [N_MEAS];
    logic signed [Y_W-1:0]   w_zx  [N_MEAS];
    logic signed [Y_W-1:0]   w_y   [N_MEAS];
    logic signed [ACC_W-1:0] w_dr  [N_EST];
    logic signed [SAT_W-1:0] w_nv  [N_EST];
    logic signed [EST_W-1:0] w_sat [N_EST];
    logic                    w_update_go;

    // constant subset-sum tables of the coefficient rows
    for (genvar gi = 0; gi < N_MEAS; gi++) begin : g_mtab_row
        for (genvar gm = 0; gm < (1 << N_EST); gm++) begin : g_mtab_ent
            assign w_meas_tab[gi][gm] = ACC_W'(meas_sum(gi, gm, COEF_FRAC_BITS));
        end
    end
    for (genvar gk = 0; gk < N_EST; gk++) begin : g_gtab_row
        for (genvar gm = 0; gm < (1 << N_MEAS); gm++) begin : g_gtab_ent
            assign w_gain_tab[gk][gm] = ACC_W'(gain_sum(gk, gm, COEF_FRAC_BITS));
        end
    end

    // serial bits presented to the tables, msb first
    always_comb begin
        for (int j = 0; j < N_EST; j++) begin
            w_xbits[j] = r_xs[j][EST_W-1];
        end
        for (int i = 0; i < N_MEAS; i++) begin
            w_ybits[i] = r_ys[i][Y_W-1];
        end
    end

    // residual: z * 16 + floor((half - zhat) / 2^F)
    always_comb begin
        for (int i = 0; i < N_MEAS; i++) begin
            w_t[i]   = HALF - r_acc[i];
            w_tsh[i] = w_t[i] >>> COEF_FRAC_BITS;
            w_zx[i]  = {{(Y_W - IN_W - Z_SHIFT){r_z[i][IN_W-1]}}, r_z[i], {Z_SHIFT{1'b0}}};
            w_y[i]   = w_tsh[i][Y_W-1:0] + w_zx[i];
        end
    end

    // rounded correction added to the estimate, then saturated
    always_comb begin
        for (int k = 0; k < N_EST; k++) begin
            w_dr[k] = (r_acc[k] + HALF) >>> COEF_FRAC_BITS;
            w_nv[k] = {{(SAT_W - EST_W){r_est[k][EST_W-1]}}, r_est[k]}
                    + {w_dr[k][Y_W-1], w_dr[k][Y_W-1:0]};
            if (w_nv[k] > EST_MAX_S) begin
                w_sat[k] = EST_MAX_S[EST_W-1:0];
            end else if (w_nv[k] < EST_MIN_S) begin
                w_sat[k] = EST_MIN_S[EST_W-1:0];
            end else begin
                w_sat[k] = w_nv[k][EST_W-1:0];
            end
        end
    end

    assign w_update_go = (r_state == S_UPDATE) && (!r_out_valid || i_out_ready);

    // sequencer and serial datapath
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_est       = r_est;
        n_acc       = r_acc;
        n_xs        = r_xs;
        n_ys        = r_ys;
        n_z         = r_z;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_z[0]  = i_wheel_speed_a;
                    n_z[1]  = i_wheel_speed_b;
                    n_z[2]  = i_wheel_speed_c;
                    n_z[3]  = i_wheel_speed_d;
                    n_z[4]  = i_gyro_rate;
                    for (int j = 0; j < N_EST; j++) begin
                        n_xs[j] = r_est[j];
                    end
                    n_cnt   = '0;
                    n_state = S_MEAS;
                end
            end
            S_MEAS: begin
                for (int i = 0; i < N_MEAS; i++) begin
                    if (r_cnt == '0) begin
                        n_acc[i] = -w_meas_tab[i][w_xbits];
                    end else begin
                        n_acc[i] = (r_acc[i] <<< 1) + w_meas_tab[i][w_xbits];
                    end
                end
                for (int j = 0; j < N_EST; j++) begin
                    n_xs[j] = {r_xs[j][EST_W-2:0], 1'b0};
                end
                if (r_cnt == CNT_W'(EST_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_RESID;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RESID: begin
                for (int i = 0; i < N_MEAS; i++) begin
                    n_ys[i] = w_y[i];
                end
                n_state = S_GAIN;
            end
            S_GAIN: begin
                for (int k = 0; k < N_EST; k++) begin
                    if (r_cnt == '0) begin
                        n_acc[k] = -w_gain_tab[k][w_ybits];
                    end else begin
                        n_acc[k] = (r_acc[k] <<< 1) + w_gain_tab[k][w_ybits];
                    end
                end
                for (int i = 0; i < N_MEAS; i++) begin
                    n_ys[i] = {r_ys[i][Y_W-2:0], 1'b0};
                end
                if (r_cnt == CNT_W'(Y_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_UPDATE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UPDATE: begin
                if (w_update_go) begin
                    n_est       = w_sat;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and estimate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < N_EST; k++) begin
                r_est[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_est       <= n_est;
        end
    end

    // serial payload registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_xs  <= n_xs;
        r_ys  <= n_ys;
        r_z   <= n_z;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_est_vx    = r_est[0];
    assign o_est_vy    = r_est[1];
    assign o_est_omega = r_est[2];

    // a result appears only out of the write step
    a_valid_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_UPDATE))
        else $error("result valid raised outside the write step");

    // an input transfer starts the measurement pass at bit zero
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_MEAS && r_cnt == '0))
        else $error("input transfer did not start the measurement pass");

    // the estimate never changes while an untaken result is shown
    a_est_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_est[0]) && $stable(r_est[1])
                                          && $stable(r_est[2]))
        else $error("estimate changed under a pending result");

endmodule
